FILE: rtl/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// LCD sequencer package
// Request codes, microcode word format and the microcode program.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

   localparam int unsigned DelayWidth = 16;
   localparam int unsigned PcWidth    = 5;

   localparam logic [DelayWidth-1:0] INIT_LONG_US  = 16'd4200;
   localparam logic [DelayWidth-1:0] INIT_SHORT_US = 16'd120;

   localparam logic [DelayWidth-1:0] RST_DATA_DELAY  = 16'd50;
   localparam logic [DelayWidth-1:0] RST_CMD_DELAY   = 16'd50;
   localparam logic [DelayWidth-1:0] RST_CLEAR_DELAY = 16'd1500;
   localparam logic [DelayWidth-1:0] RST_POWER_WAIT  = 16'd15000;

   localparam logic [7:0] CURSOR_BASE = 8'h80;

   typedef enum logic [1:0] {
      FN_INIT   = 2'd0,
      FN_CHAR   = 2'd1,
      FN_CLEAR  = 2'd2,
      FN_CURSOR = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_DATA_DELAY  = 2'd0,
      CSR_CMD_DELAY   = 2'd1,
      CSR_CLEAR_DELAY = 2'd2,
      CSR_POWER_WAIT  = 2'd3
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } seq_state_type;

   typedef enum logic [1:0] {
      NS_CONST,
      NS_OP_HI,
      NS_OP_LO
   } nib_sel_type;

   typedef enum logic [2:0] {
      SS_LONG,
      SS_SHORT,
      SS_DATA,
      SS_CMD,
      SS_CLEAR
   } settle_sel_type;

   typedef struct packed {
      nib_sel_type    nib_sel;
      logic [3:0]     nib;
      logic           rs;
      logic           power_wait;
      settle_sel_type settle_sel;
      logic           last;
   } ucode_word_type;

   // entry points
   localparam logic [PcWidth-1:0] PC_INIT   = 5'd0;
   localparam logic [PcWidth-1:0] PC_CHAR   = 5'd14;
   localparam logic [PcWidth-1:0] PC_CLEAR  = 5'd16;
   localparam logic [PcWidth-1:0] PC_CURSOR = 5'd18;

   function automatic logic [PcWidth-1:0] entry_pc(input func_type fn);
      logic [PcWidth-1:0] pc;
      unique case (fn)
         FN_INIT:   pc = PC_INIT;
         FN_CHAR:   pc = PC_CHAR;
         FN_CLEAR:  pc = PC_CLEAR;
         FN_CURSOR: pc = PC_CURSOR;
         default:   pc = PC_INIT;
      endcase
      return pc;
   endfunction

   function automatic ucode_word_type mk(input nib_sel_type sel, input logic [3:0] nib,
                                         input logic rs, input logic pw,
                                         input settle_sel_type ss, input logic last);
      ucode_word_type w;
      w.nib_sel    = sel;
      w.nib        = nib;
      w.rs         = rs;
      w.power_wait = pw;
      w.settle_sel = ss;
      w.last       = last;
      return w;
   endfunction

   function automatic ucode_word_type ucode_rom(input logic [PcWidth-1:0] pc);
      ucode_word_type w;
      unique case (pc)
         // initialization
         5'd0:    w = mk(NS_CONST, 4'h3, 1'b0, 1'b1, SS_LONG,  1'b0);
         5'd1:    w = mk(NS_CONST, 4'h3, 1'b0, 1'b0, SS_SHORT, 1'b0);
         5'd2:    w = mk(NS_CONST, 4'h3, 1'b0, 1'b0, SS_SHORT, 1'b0);
         5'd3:    w = mk(NS_CONST, 4'h2, 1'b0, 1'b0, SS_SHORT, 1'b0);
         5'd4:    w = mk(NS_CONST, 4'h2, 1'b0, 1'b0, SS_CMD,   1'b0);
         5'd5:    w = mk(NS_CONST, 4'h8, 1'b0, 1'b0, SS_CMD,   1'b0);
         5'd6:    w = mk(NS_CONST, 4'h0, 1'b0, 1'b0, SS_CMD,   1'b0);
         5'd7:    w = mk(NS_CONST, 4'h8, 1'b0, 1'b0, SS_CMD,   1'b0);
         5'd8:    w = mk(NS_CONST, 4'h0, 1'b0, 1'b0, SS_CLEAR, 1'b0);
         5'd9:    w = mk(NS_CONST, 4'h1, 1'b0, 1'b0, SS_CLEAR, 1'b0);
         5'd10:   w = mk(NS_CONST, 4'h0, 1'b0, 1'b0, SS_CMD,   1'b0);
         5'd11:   w = mk(NS_CONST, 4'h6, 1'b0, 1'b0, SS_CMD,   1'b0);
         5'd12:   w = mk(NS_CONST, 4'h0, 1'b0, 1'b0, SS_CMD,   1'b0);
         5'd13:   w = mk(NS_CONST, 4'hC, 1'b0, 1'b0, SS_CMD,   1'b1);
         // character write
         5'd14:   w = mk(NS_OP_HI, 4'h0, 1'b1, 1'b0, SS_DATA,  1'b0);
         5'd15:   w = mk(NS_OP_LO, 4'h0, 1'b1, 1'b0, SS_DATA,  1'b1);
         // clear
         5'd16:   w = mk(NS_CONST, 4'h0, 1'b0, 1'b0, SS_CLEAR, 1'b0);
         5'd17:   w = mk(NS_CONST, 4'h1, 1'b0, 1'b0, SS_CLEAR, 1'b1);
         // cursor move
         5'd18:   w = mk(NS_OP_HI, 4'h0, 1'b0, 1'b0, SS_CMD,   1'b0);
         5'd19:   w = mk(NS_OP_LO, 4'h0, 1'b0, 1'b0, SS_CMD,   1'b1);
         default: w = mk(NS_CONST, 4'h0, 1'b0, 1'b0, SS_CMD,   1'b1);
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/lcdseq_if.sv
// ----------------------------------------------------------------------------
// LCD sequencer channels
// Request and transfer channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcdseq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] char_code;
   logic       row;
   logic [5:0] col;

   modport source (output valid, func, char_code, row, col, input ready);
   modport sink   (input valid, func, char_code, row, col, output ready);
endinterface

interface lcdseq_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  nibble;
   logic        rs;
   logic [15:0] wait_before_us;
   logic [15:0] settle_us;
   logic        last;

   modport source (output valid, nibble, rs, wait_before_us, settle_us, last, input ready);
   modport sink   (input valid, nibble, rs, wait_before_us, settle_us, last, output ready);
endinterface

FILE: rtl/lcd_nibble_command_sequencer_top.sv
// A request is registered into the step counter, then its first transfer into
// the output register. Throughput: one transfer per cycle while the sink is ready,
// from a microcode step counter; a new request is accepted only once the last
// transfer of the previous one is loaded. A stalled sink holds the step.
// Reset (synchronous): sequencer idle, output empty, delay registers to defaults.
// ----------------------------------------------------------------------------
// LCD nibble command sequencer
// Microcoded sequencer that turns display requests into 4-bit transfers.
// ----------------------------------------------------------------------------
module lcd_nibble_command_sequencer_top (
   input  logic                           clock,
   input  logic                           reset,
   lcdseq_req_if.sink                     req_bus,
   lcdseq_rsp_if.source                   rsp_bus,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [lcdseq_pkg::DelayWidth-1:0] csr_wdata
);
   import lcdseq_pkg::*;

   seq_state_type             state_ff, state_in;
   logic [PcWidth-1:0]        pc_ff, pc_in;
   logic [7:0]                operand_ff, operand_in;
   logic [DelayWidth-1:0]     data_delay_ff, cmd_delay_ff, clear_delay_ff, power_wait_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [3:0]                rsp_nibble_ff, rsp_nibble_in;
   logic                      rsp_rs_ff, rsp_rs_in;
   logic [DelayWidth-1:0]     rsp_wait_ff, rsp_wait_in;
   logic [DelayWidth-1:0]     rsp_settle_ff, rsp_settle_in;
   logic                      rsp_last_ff, rsp_last_in;
   ucode_word_type            word;
   logic                      req_take;
   logic                      load_out;

   assign word     = ucode_rom(pc_ff);
   assign req_take = req_bus.valid && req_bus.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         data_delay_ff  <= RST_DATA_DELAY;
         cmd_delay_ff   <= RST_CMD_DELAY;
         clear_delay_ff <= RST_CLEAR_DELAY;
         power_wait_ff  <= RST_POWER_WAIT;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DATA_DELAY:  data_delay_ff  <= csr_wdata;
            CSR_CMD_DELAY:   cmd_delay_ff   <= csr_wdata;
            CSR_CLEAR_DELAY: clear_delay_ff <= csr_wdata;
            CSR_POWER_WAIT:  power_wait_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_RUN;
         ST_RUN:  if (load_out && word.last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_bus.ready = 1'b0;
      load_out      = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_RUN:  load_out = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   // step counter and operand
   always_comb begin
      pc_in      = pc_ff;
      operand_in = operand_ff;
      if (req_take) begin
         pc_in = entry_pc(func_type'(req_bus.func));
         if (func_type'(req_bus.func) == FN_CURSOR) begin
            operand_in = CURSOR_BASE + {1'b0, req_bus.row, 6'b0} + {2'b0, req_bus.col};
         end else begin
            operand_in = req_bus.char_code;
         end
      end else if (load_out && !word.last) begin
         pc_in = pc_ff + 1'b1;
      end
   end

   // datapath driven by the control word
   always_comb begin
      rsp_nibble_in = rsp_nibble_ff;
      rsp_rs_in     = rsp_rs_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_settle_in = rsp_settle_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_rs_in    = word.rs;
         rsp_last_in  = word.last;
         rsp_wait_in  = word.power_wait ? power_wait_ff : '0;
         case (word.nib_sel)
            NS_OP_HI: rsp_nibble_in = operand_ff[7:4];
            NS_OP_LO: rsp_nibble_in = operand_ff[3:0];
            default:  rsp_nibble_in = word.nib;
         endcase
         case (word.settle_sel)
            SS_LONG:  rsp_settle_in = INIT_LONG_US;
            SS_SHORT: rsp_settle_in = INIT_SHORT_US;
            SS_DATA:  rsp_settle_in = data_delay_ff;
            SS_CLEAR: rsp_settle_in = clear_delay_ff;
            default:  rsp_settle_in = cmd_delay_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      operand_ff    <= operand_in;
      rsp_nibble_ff <= rsp_nibble_in;
      rsp_rs_ff     <= rsp_rs_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_settle_ff <= rsp_settle_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.nibble         = rsp_nibble_ff;
   assign rsp_bus.rs             = rsp_rs_ff;
   assign rsp_bus.wait_before_us = rsp_wait_ff;
   assign rsp_bus.settle_us      = rsp_settle_ff;
   assign rsp_bus.last           = rsp_last_ff;

`ifndef SYNTHESIS
   a_req_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_RUN)
      else $error("request accepted but sequencer not running");

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> pc_ff <= PC_CURSOR + 5'd1)
      else $error("step counter outside program");

   a_wait_only_init: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wait_ff != '0 |-> rsp_nibble_ff == 4'h3 && !rsp_rs_ff)
      else $error("wait on a transfer other than the first init transfer");

   a_no_load_while_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !load_out)
      else $error("transfer loaded while idle");
`endif

endmodule
